// ----- design/dre_pkg.sv -----
`timescale 1ns / 1ps

package dre_pkg;

	// Packed colour word, green in the top byte, then red, then blue.
	localparam int unsigned DataBits = 24;
	localparam int unsigned CountW   = 5;
	localparam int unsigned TicksW   = 9;
	localparam int unsigned ChanW    = 8;
	localparam int unsigned PeakW    = 7;
	localparam int unsigned ProdW    = ChanW + PeakW;

	typedef logic [DataBits-1:0] word_t;
	typedef logic [ChanW-1:0]    chan_t;
	typedef logic [PeakW-1:0]    peak_t;
	typedef logic [ProdW-1:0]    prod_t;
	typedef logic [CountW-1:0]   count_t;
	typedef logic [TicksW-1:0]   ticks_t;

	// Dimming constants.
	localparam peak_t PeakBase  = 7'd3;
	localparam peak_t PeakCap   = 7'd75;
	localparam peak_t PeakReset = 7'd6;
	// Brightness at or above this value always reaches the cap.
	localparam chan_t CapBrightness = 8'd103;
	// Reciprocal of 100 scaled by 2^19, exact for the products that occur.
	localparam logic [12:0] RecipHundred = 13'd5243;
	localparam int unsigned RecipShift   = 19;

	// Line symbol durations in 10 MHz ticks.
	localparam ticks_t OneHigh    = 9'd7;
	localparam ticks_t OneLow     = 9'd5;
	localparam ticks_t ZeroHigh   = 9'd4;
	localparam ticks_t ZeroLow    = 9'd8;
	localparam ticks_t ResetTicks = 9'd300;

	// Symbol position of the closing reset symbol in a frame.
	localparam count_t LastIndex = 5'd24;

	// One line symbol as held in the output register.
	typedef struct packed {
		ticks_t first_ticks;
		logic   first_level;
		ticks_t second_ticks;
		logic   second_level;
		logic   last_symbol;
	} sym_t;

endpackage

// ----- design/dre_front.sv -----
`timescale 1ns / 1ps

module dre_front (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	input  logic [7:0]            cfg_data,
	input  logic                  push,
	input  logic [7:0]            red,
	input  logic [7:0]            green,
	input  logic [7:0]            blue,
	output logic                  full,
	input  logic                  q_full,
	output logic                  q_push,
	output dre_pkg::word_t        q_word
);

	dre_pkg::peak_t peak_q;
	logic           v_s1;
	dre_pkg::prod_t prod_r_s1, prod_g_s1, prod_b_s1;
	logic [2:0]     nz_s1;

	logic [13:0]    bright_x70;
	logic [26:0]    recip_mul;
	dre_pkg::peak_t peak_next;
	logic           load_s1;
	dre_pkg::chan_t dim_r, dim_g, dim_b;

	// Peak code from the written brightness: 3 + b*70/100, capped at 75.
	// A zero peak stands for a blanked LED.
	always_comb begin
		bright_x70 = (14'(cfg_data) << 6) + (14'(cfg_data) << 2) + (14'(cfg_data) << 1);
		recip_mul  = 27'(bright_x70) * 27'(dre_pkg::RecipHundred);
		if (cfg_data == 8'd0) begin
			peak_next = '0;
		end else if (cfg_data >= dre_pkg::CapBrightness) begin
			peak_next = dre_pkg::PeakCap;
		end else begin
			peak_next = dre_pkg::PeakBase
				+ recip_mul[dre_pkg::RecipShift +: dre_pkg::PeakW];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			peak_q <= dre_pkg::PeakReset;
		end else if (cfg_valid) begin
			peak_q <= peak_next;
		end
	end

	// The stage holds while the queue is full.
	assign full    = v_s1 && q_full;
	assign load_s1 = push && !full;
	assign q_push  = v_s1 && !q_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (load_s1) begin
			v_s1 <= 1'b1;
		end else if (q_push) begin
			v_s1 <= 1'b0;
		end
	end

	// Scale each channel by the peak; the nonzero marks are cleared when blanked.
	always_ff @(posedge clk) begin
		if (load_s1) begin
			prod_r_s1 <= dre_pkg::ProdW'(red) * dre_pkg::ProdW'(peak_q);
			prod_g_s1 <= dre_pkg::ProdW'(green) * dre_pkg::ProdW'(peak_q);
			prod_b_s1 <= dre_pkg::ProdW'(blue) * dre_pkg::ProdW'(peak_q);
			nz_s1     <= {red != 8'd0, green != 8'd0, blue != 8'd0}
				& {3{peak_q != '0}};
		end
	end

	// Divide by 255 and hold a nonzero channel at a minimum of one.
	function automatic dre_pkg::chan_t div255_min1(dre_pkg::prod_t x, logic nz);
		logic [15:0]    sum;
		dre_pkg::chan_t quot;
		sum  = 16'(x) + 16'(x >> 8) + 16'd1;
		quot = sum[15:8];
		if (nz && quot == '0) begin
			quot = 8'd1;
		end
		return quot;
	endfunction

	always_comb begin
		dim_r  = div255_min1(prod_r_s1, nz_s1[2]);
		dim_g  = div255_min1(prod_g_s1, nz_s1[1]);
		dim_b  = div255_min1(prod_b_s1, nz_s1[0]);
		q_word = {dim_g, dim_r, dim_b};
	end

endmodule

// ----- design/dre_queue.sv -----
`timescale 1ns / 1ps

module dre_queue #(
	parameter int unsigned DEPTH = 2
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           wr_en,
	input  dre_pkg::word_t wr_word,
	output logic           q_full,
	input  logic           rd_en,
	output logic           q_empty,
	output dre_pkg::word_t rd_word
);

	localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CntW = $clog2(DEPTH + 1);
	localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
	localparam logic [CntW-1:0] FullCnt = CntW'(DEPTH);

	dre_pkg::word_t  mem_q [DEPTH];
	logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CntW-1:0] count_q;

	assign q_full  = count_q == FullCnt;
	assign q_empty = count_q == '0;
	assign rd_word = mem_q[rd_ptr_q];

	// Storage of the queued colour words.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= wr_word;
		end
	end

	// Pointers wrap at the depth; the count tracks occupancy.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
			end
			if (rd_en) begin
				rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
			end
			if (wr_en && !rd_en) begin
				count_q <= count_q + 1'b1;
			end else if (rd_en && !wr_en) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ----- design/dre_back.sv -----
`timescale 1ns / 1ps

module dre_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           q_empty,
	input  dre_pkg::word_t q_word,
	output logic           q_pop,
	input  logic           pop,
	output logic           empty,
	output logic [8:0]     first_ticks,
	output logic           first_level,
	output logic [8:0]     second_ticks,
	output logic           second_level,
	output logic           last_symbol
);

	dre_pkg::count_t cnt_q;
	logic            out_valid_q;
	dre_pkg::sym_t   sym_q;

	logic            adv;
	logic            bit_val;
	dre_pkg::sym_t   sym_next;

	// A symbol moves into the output register when it is free or being taken.
	assign adv   = !q_empty && (!out_valid_q || pop);
	assign q_pop = adv && (cnt_q == dre_pkg::LastIndex);
	assign empty = !out_valid_q;

	// Build the symbol for the current position of the head word.
	always_comb begin
		bit_val = q_word[5'(dre_pkg::DataBits - 1) - cnt_q];
		if (cnt_q == dre_pkg::LastIndex) begin
			sym_next.first_ticks  = dre_pkg::ResetTicks;
			sym_next.first_level  = 1'b0;
			sym_next.second_ticks = dre_pkg::ResetTicks;
			sym_next.last_symbol  = 1'b1;
		end else begin
			sym_next.first_ticks  = bit_val ? dre_pkg::OneHigh : dre_pkg::ZeroHigh;
			sym_next.first_level  = 1'b1;
			sym_next.second_ticks = bit_val ? dre_pkg::OneLow : dre_pkg::ZeroLow;
			sym_next.last_symbol  = 1'b0;
		end
		sym_next.second_level = 1'b0;
	end

	// Symbol counter and output valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (adv) begin
				cnt_q <= (cnt_q == dre_pkg::LastIndex) ? '0 : cnt_q + 1'b1;
			end
			if (adv) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sym_q <= sym_next;
		end
	end

	assign first_ticks  = sym_q.first_ticks;
	assign first_level  = sym_q.first_level;
	assign second_ticks = sym_q.second_ticks;
	assign second_level = sym_q.second_level;
	assign last_symbol  = sym_q.last_symbol;

endmodule

// ----- design/dimmed_rgb_led_bit_encoder.sv -----
`timescale 1ns / 1ps
// An accepted item passes the scaling stage and the colour queue before reaching the result ports.
// Output: one symbol per cycle while each symbol is popped, from the single output register
// that walks each queued colour word bit by bit and then adds the reset symbol.
// Reset: arst_n empties the pipeline, the colour queue and the output register at once,
// and sets brightness to 5 (peak code 6).
module dimmed_rgb_led_bit_encoder #(
	parameter int unsigned QUEUE_DEPTH = 2
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [7:0] cfg_data,
	input  logic       push,
	output logic       full,
	input  logic [7:0] red,
	input  logic [7:0] green,
	input  logic [7:0] blue,
	input  logic       pop,
	output logic       empty,
	output logic [8:0] first_ticks,
	output logic       first_level,
	output logic [8:0] second_ticks,
	output logic       second_level,
	output logic       last_symbol
);

	logic           q_full, q_empty, q_push, q_pop;
	dre_pkg::word_t wr_word, rd_word;

	// The brightness register takes a write in any cycle.
	assign cfg_ready = 1'b1;

	dre_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_valid(cfg_valid),
		.cfg_data (cfg_data),
		.push     (push),
		.red      (red),
		.green    (green),
		.blue     (blue),
		.full     (full),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_word   (wr_word)
	);

	dre_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (q_push),
		.wr_word(wr_word),
		.q_full (q_full),
		.rd_en  (q_pop),
		.q_empty(q_empty),
		.rd_word(rd_word)
	);

	dre_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_empty     (q_empty),
		.q_word      (rd_word),
		.q_pop       (q_pop),
		.pop         (pop),
		.empty       (empty),
		.first_ticks (first_ticks),
		.first_level (first_level),
		.second_ticks(second_ticks),
		.second_level(second_level),
		.last_symbol (last_symbol)
	);

endmodule
